/* rtl/core/accel_frame_to_tilt_top_defines.svh */
// assertion macros for the frame to tilt block
`ifndef ACCEL_FRAME_TO_TILT_TOP_DEFINES_SVH
`define ACCEL_FRAME_TO_TILT_TOP_DEFINES_SVH
// property that must hold every cycle outside reset
`define AFT_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
// implication checked on the next cycle
`define AFT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

/* rtl/core/aft_pkg.sv */
// shared types and constants of the frame to tilt block
`default_nettype none
package aft_pkg;
   localparam int SampleW = 23;
   localparam int TiltW   = 16;
   localparam int SqW     = 48;   // width of b^2 or c^2; the radicand is b^2 + c^2, scaled by 2^16
   localparam int RootW   = 33;
   localparam int CordW   = 36;
   localparam int AngW    = 26;
   localparam logic signed [TiltW-1:0] TiltLimit = 16'sd23040;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SQ_B, ST_SQ_C, ST_ROOT, ST_CORD, ST_DONE
   } tilt_state_type;

   // atan(2^-i) in degrees, q16
   function automatic logic [AngW-1:0] atan_q16(input logic [4:0] idx);
      logic [AngW-1:0] v;
      unique case (idx)
         5'd0: v = 26'd2949120;  5'd1: v = 26'd1740967;
         5'd2: v = 26'd919879;   5'd3: v = 26'd466945;
         5'd4: v = 26'd234379;   5'd5: v = 26'd117304;
         5'd6: v = 26'd58666;    5'd7: v = 26'd29335;
         5'd8: v = 26'd14668;    5'd9: v = 26'd7334;
         5'd10: v = 26'd3667;    5'd11: v = 26'd1833;
         5'd12: v = 26'd917;     5'd13: v = 26'd458;
         5'd14: v = 26'd229;     5'd15: v = 26'd115;
         5'd16: v = 26'd57;      5'd17: v = 26'd29;
         5'd18: v = 26'd14;      5'd19: v = 26'd7;
         5'd20: v = 26'd4;       5'd21: v = 26'd2;
         5'd22: v = 26'd1;       default: v = '0;
      endcase
      return v;
   endfunction
endpackage
`default_nettype wire

/* rtl/core/aft_tilt.sv */
// one tilt angle: squares, integer root, then cordic vectoring, one step a cycle
`default_nettype none
module aft_tilt #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic signed [aft_pkg::SampleW-1:0] num_a,
   input  wire logic signed [aft_pkg::SampleW-1:0] den_b,
   input  wire logic signed [aft_pkg::SampleW-1:0] den_c,
   output logic done,
   output logic signed [aft_pkg::TiltW-1:0] angle
);
   localparam int SqW = aft_pkg::SqW;
   localparam int RootW = aft_pkg::RootW;
   localparam int CordW = aft_pkg::CordW;
   localparam int AngW = aft_pkg::AngW;
   // two radicand bits per step
   localparam int RootSteps = (SqW + 16) / 2;

   aft_pkg::tilt_state_type state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [2*RootW-1:0] rem_ff, rem_in;   // root remainder, wide
   logic [RootW-1:0] root_ff, root_in;
   logic [SqW+15:0] rad_ff, rad_in;      // radicand shifted out two bits a step
   logic signed [CordW-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [AngW+1:0] cz_ff, cz_in;
   logic signed [aft_pkg::TiltW-1:0] ang_ff, ang_in;
   logic done_ff, done_in;

   // shared multiplier operand
   logic signed [aft_pkg::SampleW-1:0] mul_op;
   logic [SqW-1:0] sq;
   logic [2*RootW-1:0] trial;
   logic signed [CordW-1:0] dx, dy;
   logic signed [AngW+1:0] zr;
   logic [4:0] idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= aft_pkg::ST_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in; rem_ff <= rem_in; root_ff <= root_in; rad_ff <= rad_in;
      cx_ff <= cx_in; cy_ff <= cy_in; cz_ff <= cz_in; ang_ff <= ang_in;
   end

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; rem_in = rem_ff; root_in = root_ff;
      rad_in = rad_ff; cx_in = cx_ff; cy_in = cy_ff; cz_in = cz_ff; ang_in = ang_ff;
      done_in = 1'b0;
      mul_op = (state_ff == aft_pkg::ST_SQ_B) ? den_b : den_c;
      sq = $unsigned(SqW'(mul_op * mul_op));
      trial = {rem_ff[2*RootW-3:0], rad_ff[SqW+15:SqW+14]};
      idx = cnt_ff[4:0];
      dx = cy_ff >>> idx;
      dy = cx_ff >>> idx;
      zr = (cz_ff + 28'sd128) >>> 8;
      unique case (state_ff)
         aft_pkg::ST_IDLE: begin
            if (start) begin
               rad_in = '0;
               state_in = aft_pkg::ST_SQ_B;
            end
         end
         aft_pkg::ST_SQ_B: begin
            rad_in = {sq, 16'd0};
            state_in = aft_pkg::ST_SQ_C;
         end
         aft_pkg::ST_SQ_C: begin
            rad_in = rad_ff + {sq, 16'd0};
            rem_in = '0; root_in = '0; cnt_in = '0;
            state_in = aft_pkg::ST_ROOT;
         end
         aft_pkg::ST_ROOT: begin
            // restoring root, one result bit a cycle
            rad_in = rad_ff << 2;
            if (trial >= {root_ff, 2'b01}) begin
               rem_in = trial - {root_ff, 2'b01};
               root_in = {root_ff[RootW-2:0], 1'b1};
            end else begin
               rem_in = trial;
               root_in = {root_ff[RootW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(RootSteps - 1)) begin
               cnt_in = '0;
               cx_in = CordW'(signed'({1'b0, root_in}));
               cy_in = CordW'(num_a) <<< 8;
               cz_in = '0;
               state_in = aft_pkg::ST_CORD;
            end
         end
         aft_pkg::ST_CORD: begin
            if (!cy_ff[CordW-1]) begin
               cx_in = cx_ff + dx; cy_in = cy_ff - dy;
               cz_in = cz_ff + signed'({2'b00, aft_pkg::atan_q16(idx)});
            end else begin
               cx_in = cx_ff - dx; cy_in = cy_ff + dy;
               cz_in = cz_ff - signed'({2'b00, aft_pkg::atan_q16(idx)});
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(CORDIC_STEPS - 1)) begin
               state_in = aft_pkg::ST_DONE;
            end
         end
         aft_pkg::ST_DONE: begin
            // special cases, then round and clamp
            if (num_a == '0) begin
               ang_in = '0;
            end else if (root_ff == '0) begin
               ang_in = num_a[aft_pkg::SampleW-1] ? -aft_pkg::TiltLimit : aft_pkg::TiltLimit;
            end else if (zr > (AngW+2)'(aft_pkg::TiltLimit)) begin
               ang_in = aft_pkg::TiltLimit;
            end else if (zr < -(AngW+2)'(aft_pkg::TiltLimit)) begin
               ang_in = -aft_pkg::TiltLimit;
            end else begin
               ang_in = zr[aft_pkg::TiltW-1:0];
            end
            done_in = 1'b1;
            state_in = aft_pkg::ST_IDLE;
         end
         default: state_in = aft_pkg::ST_IDLE;
      endcase
   end
   // done rises with the registered angle
   assign done = done_ff;
   assign angle = ang_ff;
endmodule
`default_nettype wire

/* rtl/core/accel_frame_to_tilt_top.sv */
// Channel | dir | tdata fields (low bit up)                      | tuser
// req     | in  | rx_byte[7:0]                                    | frame_start
// rsp     | out | accel_x,y,z (23 each), tilt_x,y,z (16 each),    | -
//         |     | temp_raw (8), scale_code (3), 128 bits, no pad  |
// A non-final byte is stored as it is taken. The eighth byte runs the shared tilt
// unit three times, each run going through the squares, 32 root steps and CORDIC_STEPS
// vectoring steps, and the result word is valid after the third; at the default the root loop dominates.
// Reset is synchronous; req_tready stays low while busy and while a result waits on rsp,
// and rises the cycle after the result word is taken.
`default_nettype none
module accel_frame_to_tilt_top #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic req_tready,
   input  wire logic [7:0] req_tdata,   // rx_byte
   input  wire logic req_tuser,         // frame_start
   output logic rsp_tvalid,
   input  wire logic rsp_tready,
   output logic [127:0] rsp_tdata       // accel_x,y,z, tilt_x,y,z, temp_raw, scale_code
);
   localparam int SW = aft_pkg::SampleW;
   logic [2:0] pos_ff;
   logic [7:0] store_ff [7];
   logic [6:0] sens_ff;
   logic [2:0] code_ff;
   logic busy_ff, out_ff;
   logic [1:0] ax_sel_ff;
   logic start_ff;
   logic signed [SW-1:0] ax_ff, ay_ff, az_ff;
   logic signed [15:0] t_ff [3];
   logic [6:0] sens_new;
   logic [2:0] code_new;
   logic [2:0] pos_eff;
   logic signed [SW-1:0] na, nb, nc;
   logic tdone;
   logic signed [15:0] tang;
   logic take;

   assign req_tready = !busy_ff && !out_ff;
   assign take = req_tvalid && req_tready;
   assign pos_eff = req_tuser ? 3'd0 : pos_ff;
   assign code_new = req_tdata[5:3];

   // sensitivity lookup; reserved codes hold
   always_comb begin
      unique case (code_new)
         3'd0: sens_new = 7'd6;
         3'd1: sens_new = 7'd12;
         3'd2: sens_new = 7'd18;
         3'd3: sens_new = 7'd24;
         3'd4: sens_new = 7'd73;
         default: sens_new = sens_ff;
      endcase
   end

   // operand rotation for the three tilts
   always_comb begin
      unique case (ax_sel_ff)
         2'd0: begin na = ax_ff; nb = ay_ff; nc = az_ff; end
         2'd1: begin na = ay_ff; nb = ax_ff; nc = az_ff; end
         default: begin na = az_ff; nb = ay_ff; nc = ax_ff; end
      endcase
   end

   aft_tilt #(.CORDIC_STEPS(CORDIC_STEPS)) u_tilt (
      .clock(clock), .reset(reset), .start(start_ff),
      .num_a(na), .den_b(nb), .den_c(nc), .done(tdone), .angle(tang)
   );

   // frame capture and sequencing
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0; sens_ff <= '0; busy_ff <= 1'b0; out_ff <= 1'b0;
         start_ff <= 1'b0; ax_sel_ff <= '0;
      end else begin
         start_ff <= 1'b0;
         if (take) begin
            if (pos_eff != 3'd7) begin
               store_ff[pos_eff] <= req_tdata;
               pos_ff <= pos_eff + 3'd1;
            end else begin
               pos_ff <= '0;
               sens_ff <= sens_new;
               code_ff <= code_new;
               ax_ff <= SW'($signed({store_ff[1], store_ff[0]}) * $signed({1'b0, sens_new}));
               ay_ff <= SW'($signed({store_ff[3], store_ff[2]}) * $signed({1'b0, sens_new}));
               az_ff <= SW'($signed({store_ff[5], store_ff[4]}) * $signed({1'b0, sens_new}));
               busy_ff <= 1'b1; start_ff <= 1'b1; ax_sel_ff <= '0;
            end
         end
         if (busy_ff && tdone) begin
            t_ff[ax_sel_ff] <= tang;
            if (ax_sel_ff == 2'd2) begin
               busy_ff <= 1'b0; out_ff <= 1'b1;
            end else begin
               ax_sel_ff <= ax_sel_ff + 2'd1; start_ff <= 1'b1;
            end
         end
         if (rsp_tvalid && rsp_tready) out_ff <= 1'b0;
      end
   end

   // result word, fields from the lowest bit up
   logic signed [15:0] tz_cur;
   assign tz_cur = t_ff[2];
   assign rsp_tvalid = out_ff;
   assign rsp_tdata = {code_ff, store_ff[6], tz_cur, t_ff[1], t_ff[0],
                       az_ff, ay_ff, ax_ff};

`include "accel_frame_to_tilt_top_defines.svh"
   `AFT_ASSERT_ALWAYS(a_not_both, clock, reset, !(busy_ff && out_ff))
   `AFT_ASSERT_NEXT(a_last_done, clock, reset, busy_ff && tdone && ax_sel_ff == 2'd2, rsp_tvalid)
   `AFT_ASSERT_NEXT(a_hold_out, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
endmodule
`default_nettype wire
